// ----- rtl/sha256_byte_stream_hasher_defines.svh -----
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
`define SBH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SBH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/sbh_pkg.sv -----
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
`default_nettype none
package sbh_pkg;
	localparam logic [1:0] MODE_ABSORB = 2'd0;
	localparam logic [1:0] MODE_ABSORB_FINISH = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	// Classified request passed from the front end to the engine.
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       finish;
	} sbh_cmd_t;

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6A09E667;
			3'd1: r = 32'hBB67AE85;
			3'd2: r = 32'h3C6EF372;
			3'd3: r = 32'hA54FF53A;
			3'd4: r = 32'h510E527F;
			3'd5: r = 32'h9B05688C;
			3'd6: r = 32'h1F83D9AB;
			default: r = 32'h5BE0CD19;
		endcase
		return r;
	endfunction

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
		32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
		32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
		32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
		32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
		32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction
endpackage
`default_nettype wire

// ----- rtl/sbh_front.sv -----
// Front end: accepts input requests, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module sbh_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid,
	output logic                  stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic [1:0]       mode,
	output logic                  cmd_valid,
	output sbh_pkg::sbh_cmd_t     cmd,
	input  wire logic             cmd_take
);
	sbh_pkg::sbh_cmd_t mem_q [sbh_pkg::QUEUE_DEPTH];
	logic [sbh_pkg::QUEUE_AW-1:0] wr_q, rd_q;
	logic [sbh_pkg::QUEUE_AW:0]   cnt_q;
	logic push, pop;
	sbh_pkg::sbh_cmd_t new_cmd;

	assign stall = (cnt_q == 3'(sbh_pkg::QUEUE_DEPTH));
	// Unused mode codes are dropped here and never reach the engine.
	assign push = valid && !stall && (mode != sbh_pkg::MODE_UNUSED);
	assign pop = cmd_take && cmd_valid;
	assign cmd_valid = (cnt_q != '0);
	assign cmd = mem_q[rd_q];

	always_comb begin
		new_cmd.data = data_byte;
		new_cmd.has_byte = (mode != sbh_pkg::MODE_FINISH);
		new_cmd.finish = (mode != sbh_pkg::MODE_ABSORB);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/sbh_engine.sv -----
// Back end: block buffer, padding sequencer, compression rounds and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sbh_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  sbh_pkg::sbh_cmd_t  cmd,
	output logic               cmd_take,
	output logic               valid,
	input  wire logic          stall,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               last_word,
	output logic               busy
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [5:0]  round_q;
	logic        fin_q;   // finish pending after current byte work
	logic        padding_q;
	logic        lenblk_q; // the block being padded ends with the length
	logic [2:0]  out_q;

	logic        put;
	logic [7:0]  put_byte;
	logic [31:0] w_new, t1, t2, wi;

	assign cmd_take = (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign valid = (state_q == ST_OUT);
	assign digest_word = h_q[out_q];
	assign word_index = out_q;
	assign last_word = (out_q == 3'd7);

	// Byte written into the buffer this cycle, from a command or from padding.
	always_comb begin
		put = 1'b0;
		put_byte = 8'h00;
		if (state_q == ST_IDLE && cmd_valid) begin
			put = cmd.has_byte;
			put_byte = cmd.data;
		end else if (state_q == ST_PAD) begin
			put = 1'b1;
			if (!padding_q) begin
				put_byte = 8'h80;
			end else if (lenblk_q && fill_q >= 6'd56) begin
				put_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
			end else begin
				put_byte = 8'h00;
			end
		end
	end

	always_comb begin
		wi = w_q[0];
		w_new = w_q[0] + sbh_pkg::ssig0(w_q[1]) + w_q[9] + sbh_pkg::ssig1(w_q[14]);
		t1 = v_q[7] + sbh_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sbh_pkg::ROUND_K[round_q] + wi;
		t2 = sbh_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (put) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= put_byte;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
		if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (put && fill_q == 6'd63) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			len_q <= '0;
			round_q <= '0;
			fin_q <= 1'b0;
			padding_q <= 1'b0;
			lenblk_q <= 1'b0;
			out_q <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sbh_pkg::init_hash(3'(i));
			end
		end else begin
			if (put) begin
				fill_q <= fill_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						logic [63:0] nb;
						nb = bits_q + (cmd.has_byte ? 64'd8 : 64'd0);
						bits_q <= nb;
						len_q <= nb;
						fin_q <= cmd.finish;
						padding_q <= 1'b0;
						lenblk_q <= 1'b0;
						if (cmd.has_byte && fill_q == 6'd63) begin
							state_q <= ST_ROUND;
							round_q <= '0;
						end else if (cmd.finish) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					padding_q <= 1'b1;
					// The length fits behind the 0x80 byte only if it lands before byte 56.
					if (!padding_q) begin
						lenblk_q <= (fill_q < 6'd56);
					end
					if (fill_q == 6'd63) begin
						state_q <= ST_ROUND;
						round_q <= '0;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 1'b1;
					if (round_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (lenblk_q) begin
						state_q <= ST_OUT;
						out_q <= '0;
					end else begin
						// The next padded block always carries the length.
						state_q <= ST_PAD;
						lenblk_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (!stall) begin
						out_q <= out_q + 1'b1;
						if (out_q == 3'd7) begin
							state_q <= ST_IDLE;
							fin_q <= 1'b0;
							bits_q <= '0;
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= sbh_pkg::init_hash(3'(i));
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
`default_nettype none
// Usage: each input request carries one message byte and a mode: 0 absorbs
// the byte, 1 absorbs it and finishes the message, 2 finishes without a byte;
// mode 3 is dropped. A request is taken when valid is high and stall is low.
// A finish produces eight output requests, digest word 0 (most significant)
// first, with last_word set on word 7; the block then starts a new message.
// An accepted request is registered in the queue and reaches the engine from there.
// Engine: a plain byte goes straight into the block buffer while idle; each
// full 64-byte block runs its rounds and fold in the shared round unit, and no
// command is taken meanwhile. Finishing pads one byte a cycle to the block end
// (one or two blocks), then shows one digest word a cycle while not stalled.
// A four-entry command queue sits between the front end and the engine, so
// bytes are still accepted while the engine compresses until it fills.
// Reset clears the queue, the counters and loads the initial hash values.
// When the receiver stalls, the current digest word holds and the engine
// waits; the queue keeps taking requests until full.
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [1:0]  mode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	logic              cmd_valid, cmd_take, busy;
	sbh_pkg::sbh_cmd_t cmd;

	sbh_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.data_byte(data_byte), .mode(mode),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	sbh_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .valid(out_valid), .stall(out_stall),
		.digest_word(digest_word), .word_index(word_index),
		.last_word(last_word), .busy(busy)
	);

	// The engine only reads commands while idle.
	`SBH_ASSERT_IMPL(a_take_idle, clk, arst_n, cmd_take, !busy)
	// Last word flag agrees with the index.
	`SBH_ASSERT_IMPL(a_last_idx, clk, arst_n, out_valid && last_word, word_index == 3'd7)
	// After the last word is taken the output goes quiet.
	`SBH_ASSERT_NEXT(a_last_end, clk, arst_n, out_valid && last_word && !out_stall, !out_valid)
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps
module tb_top;
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] mode;
	} byte_req_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_req_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic [1:0]  mode;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_byte_stream_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .mode(mode),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Requests waiting to be offered, and digest words still owed by the block.
	byte_req_t   pending_bytes[$];
	digest_req_t owed_words[$];

	// The testbench's own copy of the hashing state.
	logic [31:0] hash_state[8];
	logic [7:0]  blk_bytes[64];
	int unsigned blk_fill;
	logic [63:0] msg_bits;

	int  errors;
	int  idle_cycles;
	bit  hold_off_req;
	bit  hold_done;

	localparam logic [31:0] IV [8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372,
		32'hA54FF53A, 32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of the gathered block into the chaining words.
	task automatic compress_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sbh_pkg::ROUND_K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic gather_byte(input logic [7:0] b);
		blk_bytes[blk_fill] = b;
		blk_fill++;
		if (blk_fill == 64) begin
			compress_block();
			blk_fill = 0;
		end
	endtask

	// Applies one accepted request to the model and queues any digest it yields.
	task automatic hash_request(input byte_req_t r);
		logic [63:0] len;
		digest_req_t d;
		if (r.mode == sbh_pkg::MODE_UNUSED)
			return;
		if (r.mode != sbh_pkg::MODE_FINISH) begin
			msg_bits += 64'd8;
			gather_byte(r.data);
		end
		if (r.mode == sbh_pkg::MODE_ABSORB)
			return;
		len = msg_bits;
		gather_byte(8'h80);
		while (blk_fill != 56)
			gather_byte(8'h00);
		for (int i = 0; i < 8; i++)
			gather_byte(len[8*(7-i) +: 8]);
		for (int i = 0; i < 8; i++) begin
			d.word = hash_state[i];
			d.idx = 3'(i);
			d.last = (i == 7);
			owed_words.insert(owed_words.size(), d);
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = IV[i];
		blk_fill = 0;
		msg_bits = '0;
	endtask

	task automatic queue_message(input int len, input bit fin_with_byte);
		byte_req_t r;
		for (int i = 0; i < len; i++) begin
			r.data = 8'($urandom);
			r.mode = (fin_with_byte && i == len - 1) ? sbh_pkg::MODE_ABSORB_FINISH
				: sbh_pkg::MODE_ABSORB;
			pending_bytes.insert(pending_bytes.size(), r);
		end
		if (!fin_with_byte || len == 0) begin
			r.data = 8'($urandom);
			r.mode = sbh_pkg::MODE_FINISH;
			pending_bytes.insert(pending_bytes.size(), r);
		end
	endtask

	// Driver: sends in bursts of random length separated by random gaps.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			mode <= sbh_pkg::MODE_ABSORB;
			burst_left = 0;
			gap_left = 0;
			for (int i = 0; i < 8; i++)
				hash_state[i] = IV[i];
			blk_fill = 0;
			msg_bits = '0;
		end else begin
			if (in_valid && !in_stall) begin
				hash_request({data_byte, mode});
				void'(pending_bytes.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
				if (gap_left > 0 && burst_left == 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					if (burst_left > 0)
						burst_left--;
					in_valid <= 1'b1;
					data_byte <= pending_bytes[0].data;
					mode <= pending_bytes[0].mode;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold-off requested by the stimulus.
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= (hold_left != 0);
		end else if (hold_off_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 400;
			out_stall <= 1'b1;
		end else begin
			case ($urandom_range(0, 7))
				0, 1: out_stall <= 1'b1;
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// Monitor: compares each digest word with the oldest owed one.
	digest_req_t exp_w;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (owed_words.size() == 0) begin
				$error("unexpected digest word %h", digest_word);
				errors++;
			end else begin
				exp_w = owed_words.pop_front();
				if (digest_word !== exp_w.word) begin
					$error("digest_word exp %h got %h", exp_w.word, digest_word);
					errors++;
				end
				if (word_index !== exp_w.idx) begin
					$error("word_index exp %0d got %0d", exp_w.idx, word_index);
					errors++;
				end
				if (last_word !== exp_w.last) begin
					$error("last_word exp %0d got %0d", exp_w.last, last_word);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel accepts a request.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		byte_req_t r;
		int lens[$];
		int n;
		hold_off_req = 1'b0;
		arst_n = 1'b0;

		// Directed: empty message, mode 3 ignored, extreme bytes, both finishes.
		queue_message(0, 0);
		r.data = 8'hFF; r.mode = sbh_pkg::MODE_UNUSED;
		pending_bytes.insert(pending_bytes.size(), r);
		r.data = 8'h00; r.mode = sbh_pkg::MODE_ABSORB;
		pending_bytes.insert(pending_bytes.size(), r);
		r.data = 8'hFF; r.mode = sbh_pkg::MODE_ABSORB;
		pending_bytes.insert(pending_bytes.size(), r);
		r.data = 8'hA5; r.mode = sbh_pkg::MODE_ABSORB_FINISH;
		pending_bytes.insert(pending_bytes.size(), r);
		r.data = 8'h5A; r.mode = sbh_pkg::MODE_UNUSED;
		pending_bytes.insert(pending_bytes.size(), r);
		r.data = 8'h00; r.mode = sbh_pkg::MODE_ABSORB_FINISH;
		pending_bytes.insert(pending_bytes.size(), r);
		queue_message(0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Padding boundaries: the 0x80 byte lands on byte 55, then on byte 56.
		lens = '{55, 56};
		foreach (lens[i])
			queue_message(lens[i], i[0]);

		// The receiver holds off once, long enough for the input to back up.
		hold_off_req = 1'b1;

		// Random part: short messages with random content, plus stray mode 3.
		n = pending_bytes.size();
		while (n < 180) begin
			int len;
			len = (n < 130 && $urandom_range(0, 2) == 0) ? $urandom_range(50, 70)
				: $urandom_range(0, 12);
			queue_message(len, $urandom_range(0, 1));
			n += len + 1;
			if ($urandom_range(0, 4) == 0) begin
				r.data = 8'($urandom); r.mode = sbh_pkg::MODE_UNUSED;
				pending_bytes.insert(pending_bytes.size(), r);
				n++;
			end
		end

		wait (pending_bytes.size() == 0 && !in_valid);
		wait (owed_words.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && owed_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/sbh_pkg.sv
rtl/sbh_front.sv
rtl/sbh_engine.sv
rtl/sha256_byte_stream_hasher.sv
test/tb_top.sv
